// ===== hdl/calc_pkg.sv =====
// ----------------------------------------------------------------------------
// calc_pkg
// Types and constants for the two-operand integer calculator.
// ----------------------------------------------------------------------------
package calc_pkg;

    localparam int LINE_CHARS = 32;
    localparam int WORD_BITS  = 16;

    localparam int CH_W     = 8;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 16;
    localparam int M_DATA_W = ((STATUS_W + VALUE_W + 7) / 8) * 8;
    localparam int CNT_W    = $clog2(WORD_BITS);
    localparam int TAKEN_W  = $clog2(LINE_CHARS + 1);

    localparam logic [CH_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CH_W-1:0] CH_LF    = 8'd10;
    localparam logic [CH_W-1:0] CH_CR    = 8'd13;
    localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CH_W-1:0] CH_STAR  = 8'd42;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CH_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CH_W-1:0] CH_SLASH = 8'd47;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CH_W-1:0] CH_NINE  = 8'd57;
    localparam logic [CH_W-1:0] CH_UQ    = 8'd81;
    localparam logic [CH_W-1:0] CH_LQ    = 8'd113;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ERR  = 2'd1,
        ST_DIVZ = 2'd2,
        ST_QUIT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [7:0] {
        PH_START   = 8'b0000_0001,
        PH_QSEEN   = 8'b0000_0010,
        PH_LEFT    = 8'b0000_0100,
        PH_LEFTSP  = 8'b0000_1000,
        PH_OPSEEN  = 8'b0001_0000,
        PH_RIGHT   = 8'b0010_0000,
        PH_RIGHTSP = 8'b0100_0000,
        PH_ERROR   = 8'b1000_0000
    } phase_t;

    typedef enum logic [2:0] {
        CTL_IDLE = 3'b001,
        CTL_MUL  = 3'b010,
        CTL_DIV  = 3'b100
    } ctl_t;

endpackage

// ===== hdl/infix_two_operand_calculator_core.sv =====
// ----------------------------------------------------------------------------
// infix_two_operand_calculator_core
// Parses "A op B" one character per request and returns status and value
// on each line end. Multiply and divide run bit-serially on a shared datapath.
// ----------------------------------------------------------------------------
// A character is parsed in the cycle it is taken; a line end shows its result
//   in the next cycle for + and -, errors and quit, and once the bit-serial
//   loop ends for * and / (one bit per cycle, shift-add or restoring divide).
// Throughput: one character per cycle when nothing holds the input; a * or /
//   line end holds it until its result is made; it also waits on a held result.
// Reset: aresetn synchronous, active low; parser returns to line start.
// ----------------------------------------------------------------------------
module infix_two_operand_calculator_core
    import calc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [CH_W-1:0]     s_tdata,   // [7:0] ch
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [1:0] status, [17:2] value, rest 0
);

    phase_t                 phase_reg, phase_next;
    ctl_t                   ctl_reg, ctl_next;
    op_t                    op_reg, op_next;
    logic [WORD_BITS-1:0]   left_reg, left_next;
    logic [WORD_BITS-1:0]   right_reg, right_next;
    logic [WORD_BITS-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [TAKEN_W-1:0]     taken_reg, taken_next;
    logic                   m_valid_reg, m_valid_next;
    status_t                m_status_reg, m_status_next;
    logic [VALUE_W-1:0]     m_value_reg, m_value_next;

    logic                   s_take, out_free, line_end, is_blank, is_digit, is_op;
    op_t                    ch_op;
    logic [WORD_BITS-1:0]   ch_digit, left_acc, right_acc;
    logic [WORD_BITS:0]     div_shift, div_diff;
    logic                   div_ge, last_step;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (ctl_reg == CTL_IDLE) && out_free;
    assign s_take   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-STATUS_W-VALUE_W){1'b0}}, m_value_reg, m_status_reg};

    assign line_end = (s_tdata == CH_CR) || (s_tdata == CH_LF) || (s_tdata == CH_NUL);
    assign is_blank = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB);
    assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
    assign ch_digit = WORD_BITS'(s_tdata[3:0]);

    always_comb begin
        is_op = 1'b1;
        ch_op = OP_ADD;
        unique case (s_tdata)
            CH_PLUS:  ch_op = OP_ADD;
            CH_MINUS: ch_op = OP_SUB;
            CH_STAR:  ch_op = OP_MUL;
            CH_SLASH: ch_op = OP_DIV;
            default:  is_op = 1'b0;
        endcase
    end

    // acc * 10 + digit
    assign left_acc  = {left_reg[WORD_BITS-4:0], 3'b000} + {left_reg[WORD_BITS-2:0], 1'b0}
                     + ch_digit;
    assign right_acc = {right_reg[WORD_BITS-4:0], 3'b000} + {right_reg[WORD_BITS-2:0], 1'b0}
                     + ch_digit;

    // restoring divide step: remainder in acc_reg, quotient shifts through left_reg
    assign div_shift = {acc_reg, left_reg[WORD_BITS-1]};
    assign div_diff  = div_shift - {1'b0, right_reg};
    assign div_ge    = div_shift >= {1'b0, right_reg};
    assign last_step = cnt_reg == CNT_W'(WORD_BITS - 1);

    always_comb begin
        phase_next    = phase_reg;
        ctl_next      = ctl_reg;
        op_next       = op_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        taken_next    = taken_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;

        unique case (ctl_reg)
            CTL_IDLE: begin
                if (s_take && line_end) begin
                    phase_next    = PH_START;
                    taken_next    = '0;
                    cnt_next      = '0;
                    acc_next      = '0;
                    m_valid_next  = 1'b1;
                    m_value_next  = '0;
                    m_status_next = ST_ERR;
                    if (phase_reg == PH_QSEEN) begin
                        m_status_next = ST_QUIT;
                    end else if (phase_reg == PH_RIGHT || phase_reg == PH_RIGHTSP) begin
                        unique case (op_reg)
                            OP_ADD: begin
                                m_status_next = ST_OK;
                                m_value_next  = VALUE_W'(left_reg + right_reg);
                            end
                            OP_SUB: begin
                                if (right_reg <= left_reg) begin
                                    m_status_next = ST_OK;
                                    m_value_next  = VALUE_W'(left_reg - right_reg);
                                end
                            end
                            OP_MUL: begin
                                m_valid_next = 1'b0;
                                ctl_next     = CTL_MUL;
                            end
                            OP_DIV: begin
                                if (right_reg == '0) begin
                                    m_status_next = ST_DIVZ;
                                end else begin
                                    m_valid_next = 1'b0;
                                    ctl_next     = CTL_DIV;
                                end
                            end
                        endcase
                    end
                end else if (s_take && (taken_reg < TAKEN_W'(LINE_CHARS))) begin
                    taken_next = taken_reg + 1'b1;
                    unique case (phase_reg)
                        PH_START: begin
                            priority if (is_blank) begin
                            end else if (s_tdata == CH_UQ || s_tdata == CH_LQ) begin
                                phase_next = PH_QSEEN;
                            end else if (is_digit) begin
                                left_next  = ch_digit;
                                phase_next = PH_LEFT;
                            end else begin
                                phase_next = PH_ERROR;
                            end
                        end
                        PH_QSEEN: begin
                            if (!is_blank) phase_next = PH_ERROR;
                        end
                        PH_LEFT: begin
                            priority if (is_digit) begin
                                left_next = left_acc;
                            end else if (is_blank) begin
                                phase_next = PH_LEFTSP;
                            end else if (is_op) begin
                                op_next    = ch_op;
                                phase_next = PH_OPSEEN;
                            end else begin
                                phase_next = PH_ERROR;
                            end
                        end
                        PH_LEFTSP: begin
                            priority if (is_blank) begin
                            end else if (is_op) begin
                                op_next    = ch_op;
                                phase_next = PH_OPSEEN;
                            end else begin
                                phase_next = PH_ERROR;
                            end
                        end
                        PH_OPSEEN: begin
                            priority if (is_blank) begin
                            end else if (is_digit) begin
                                right_next = ch_digit;
                                phase_next = PH_RIGHT;
                            end else begin
                                phase_next = PH_ERROR;
                            end
                        end
                        PH_RIGHT: begin
                            priority if (is_digit) begin
                                right_next = right_acc;
                            end else if (is_blank) begin
                                phase_next = PH_RIGHTSP;
                            end else begin
                                phase_next = PH_ERROR;
                            end
                        end
                        PH_RIGHTSP: begin
                            if (!is_blank) phase_next = PH_ERROR;
                        end
                        PH_ERROR: begin
                        end
                    endcase
                end
            end
            CTL_MUL: begin
                if (right_reg[0]) acc_next = acc_reg + left_reg;
                left_next  = {left_reg[WORD_BITS-2:0], 1'b0};
                right_next = {1'b0, right_reg[WORD_BITS-1:1]};
                cnt_next   = cnt_reg + 1'b1;
                if (last_step) begin
                    ctl_next      = CTL_IDLE;
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_value_next  = VALUE_W'(right_reg[0] ? acc_reg + left_reg : acc_reg);
                end
            end
            CTL_DIV: begin
                acc_next  = div_ge ? div_diff[WORD_BITS-1:0] : div_shift[WORD_BITS-1:0];
                left_next = {left_reg[WORD_BITS-2:0], div_ge};
                cnt_next  = cnt_reg + 1'b1;
                if (last_step) begin
                    ctl_next      = CTL_IDLE;
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_value_next  = VALUE_W'({left_reg[WORD_BITS-2:0], div_ge});
                end
            end
            default: begin
                ctl_next = CTL_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_START;
            ctl_reg     <= CTL_IDLE;
            op_reg      <= OP_ADD;
            taken_reg   <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            ctl_reg     <= ctl_next;
            op_reg      <= op_next;
            taken_reg   <= taken_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        left_reg     <= left_next;
        right_reg    <= right_next;
        acc_reg      <= acc_next;
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
    end

`ifndef SYNTHESIS
    a_busy_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl_reg != CTL_IDLE) |-> !m_valid_reg)
        else $error("result pending while iterating");

    a_fail_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != ST_OK)) |-> (m_value_reg == '0))
        else $error("non-zero value with failing status");

    a_quick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_take && line_end && phase_reg != PH_RIGHT && phase_reg != PH_RIGHTSP)
        |=> m_valid_reg)
        else $error("line end without prompt result");

    a_taken_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        taken_reg <= TAKEN_W'(LINE_CHARS))
        else $error("character count past line length");
`endif

endmodule

// ===== test/tb_infix_two_operand_calculator_core.sv =====
// ----------------------------------------------------------------------------
// tb_infix_two_operand_calculator_core
// Streams text lines into the calculator core one character per request and
// checks each status/value result against a line parser kept in the bench.
// ----------------------------------------------------------------------------
module tb_infix_two_operand_calculator_core
    import calc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
    } calc_result_t;

    class calc_scoreboard;
        calc_result_t       due_results[$];
        phase_t             parse_ph;
        logic [VALUE_W-1:0] lhs;
        logic [VALUE_W-1:0] rhs;
        op_t                op_sel;
        int                 taken;
        int                 fails;

        function new();
            fails = 0;
            clear_line();
        endfunction

        function void clear_line();
            parse_ph = PH_START;
            lhs      = '0;
            rhs      = '0;
            op_sel   = OP_ADD;
            taken    = 0;
        endfunction

        function logic [VALUE_W-1:0] shift_digit(logic [VALUE_W-1:0] acc,
                                                 logic [CH_W-1:0] c);
            return acc * VALUE_W'(10) + VALUE_W'(c - CH_ZERO);
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void take_char(logic [CH_W-1:0] c);
            calc_result_t r;
            logic         is_blank;
            logic         is_digit;
            logic         is_op;
            op_t          op_c;
            phase_t       next_ph;

            if (c == CH_CR || c == CH_LF || c == CH_NUL) begin
                r.value  = '0;
                r.status = ST_OK;
                if (parse_ph == PH_QSEEN) begin
                    r.status = ST_QUIT;
                end else if (parse_ph != PH_RIGHT && parse_ph != PH_RIGHTSP) begin
                    r.status = ST_ERR;
                end else begin
                    case (op_sel)
                        OP_ADD: r.value = lhs + rhs;
                        OP_SUB: begin
                            if (rhs > lhs) r.status = ST_ERR;
                            else r.value = lhs - rhs;
                        end
                        OP_MUL: r.value = lhs * rhs;
                        default: begin
                            if (rhs == '0) r.status = ST_DIVZ;
                            else r.value = lhs / rhs;
                        end
                    endcase
                end
                due_results.push_back(r);
                clear_line();
                return;
            end

            // past the line limit only the line end counts
            if (taken >= LINE_CHARS) return;
            taken++;

            is_blank = (c == CH_SPACE || c == CH_TAB);
            is_digit = (c >= CH_ZERO && c <= CH_NINE);
            is_op    = 1'b1;
            op_c     = OP_ADD;
            if (c == CH_PLUS) op_c = OP_ADD;
            else if (c == CH_MINUS) op_c = OP_SUB;
            else if (c == CH_STAR) op_c = OP_MUL;
            else if (c == CH_SLASH) op_c = OP_DIV;
            else is_op = 1'b0;

            next_ph = PH_ERROR;
            case (parse_ph)
                PH_START: begin
                    if (is_blank) next_ph = PH_START;
                    else if (c == CH_UQ || c == CH_LQ) next_ph = PH_QSEEN;
                    else if (is_digit) begin
                        lhs     = shift_digit('0, c);
                        next_ph = PH_LEFT;
                    end
                end
                PH_QSEEN: begin
                    if (is_blank) next_ph = PH_QSEEN;
                end
                PH_LEFT: begin
                    if (is_digit) begin
                        lhs     = shift_digit(lhs, c);
                        next_ph = PH_LEFT;
                    end else if (is_blank) next_ph = PH_LEFTSP;
                    else if (is_op) begin
                        op_sel  = op_c;
                        next_ph = PH_OPSEEN;
                    end
                end
                PH_LEFTSP: begin
                    if (is_blank) next_ph = PH_LEFTSP;
                    else if (is_op) begin
                        op_sel  = op_c;
                        next_ph = PH_OPSEEN;
                    end
                end
                PH_OPSEEN: begin
                    if (is_blank) next_ph = PH_OPSEEN;
                    else if (is_digit) begin
                        rhs     = shift_digit('0, c);
                        next_ph = PH_RIGHT;
                    end
                end
                PH_RIGHT: begin
                    if (is_digit) begin
                        rhs     = shift_digit(rhs, c);
                        next_ph = PH_RIGHT;
                    end else if (is_blank) next_ph = PH_RIGHTSP;
                end
                PH_RIGHTSP: begin
                    if (is_blank) next_ph = PH_RIGHTSP;
                end
                default: next_ph = PH_ERROR;
            endcase
            parse_ph = next_ph;
        endfunction

        function void check_result(logic [M_DATA_W-1:0] d);
            calc_result_t r;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, actual status %0d value %0d",
                         $time, d[STATUS_W-1:0], d[STATUS_W +: VALUE_W]);
                fails++;
                return;
            end
            r = due_results.pop_front();
            if (d[STATUS_W-1:0] != r.status) begin
                $display("%0t: status mismatch, expected %0d actual %0d",
                         $time, r.status, d[STATUS_W-1:0]);
                fails++;
            end
            if (d[STATUS_W +: VALUE_W] != r.value) begin
                $display("%0t: value mismatch, expected %0d actual %0d",
                         $time, r.value, d[STATUS_W +: VALUE_W]);
                fails++;
            end
            if ((d >> (STATUS_W + VALUE_W)) != '0) begin
                $display("%0t: pad bits mismatch, expected 0 actual %0h",
                         $time, d >> (STATUS_W + VALUE_W));
                fails++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [CH_W-1:0]     s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    calc_scoreboard      sb;
    logic [CH_W-1:0]     line_buf[$];
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  hold_req      = 0;
    int                  hold_left     = 0;
    int                  chars_sent    = 0;

    infix_two_operand_calculator_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // receiver: random back-pressure, plus long hold-offs on request
    always @(negedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.take_char(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    task automatic send_char(logic [CH_W-1:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        chars_sent++;
    endtask

    // appends body and terminator to whatever is already queued, then sends it
    task automatic send_line(string body, logic [CH_W-1:0] term);
        for (int i = 0; i < body.len(); i++) line_buf.push_back(body[i]);
        line_buf.push_back(term);
        while (line_buf.size() > 0) send_char(line_buf.pop_front());
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic void add_blanks();
        int n;
        n = ($urandom_range(19) == 0) ? $urandom_range(30, 10) : $urandom_range(2);
        repeat (n) line_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    endfunction

    function automatic void add_number();
        int n;
        if ($urandom_range(6) == 0) begin
            line_buf.push_back(CH_ZERO);
        end else begin
            n = ($urandom_range(9) == 0) ? $urandom_range(7, 5) : $urandom_range(3, 1);
            repeat (n) line_buf.push_back(CH_ZERO + CH_W'($urandom_range(9)));
        end
    endfunction

    function automatic logic [CH_W-1:0] pick_term();
        case ($urandom_range(2))
            0:       return CH_CR;
            1:       return CH_LF;
            default: return CH_NUL;
        endcase
    endfunction

    task automatic random_line();
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 88 && kind >= 70 && kind < 78) begin
            add_blanks();
            line_buf.push_back($urandom_range(1) ? CH_UQ : CH_LQ);
            add_blanks();
        end else if (kind < 90) begin
            add_blanks();
            add_number();
            add_blanks();
            case ($urandom_range(3))
                0:       line_buf.push_back(CH_PLUS);
                1:       line_buf.push_back(CH_MINUS);
                2:       line_buf.push_back(CH_STAR);
                default: line_buf.push_back(CH_SLASH);
            endcase
            add_blanks();
            add_number();
            add_blanks();
            if (kind >= 78) begin
                // insert one random character at a random position
                n = $urandom_range(line_buf.size());
                line_buf.insert(n, CH_W'($urandom_range(255)));
            end
        end else begin
            n = $urandom_range(12);
            repeat (n) line_buf.push_back(CH_W'($urandom_range(255)));
        end
        send_line("", pick_term());
    endtask

    task automatic random_phase(int s_pct, int r_pct, int n_chars);
        int goal;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        goal = chars_sent + n_chars;
        while (chars_sent < goal) random_line();
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 0;
        recv_idle_pct = 30;
        send_line("12+34", CH_CR);
        send_line("  65535 * 65535 ", CH_LF);
        send_line("99999+1", CH_NUL);
        send_line("100-7", CH_CR);
        send_line("7 - 100", CH_CR);
        send_line("65535-65535", CH_LF);
        send_line("1000/7", CH_CR);
        send_line("5 / 0", CH_CR);
        send_line("0/0", CH_NUL);
        send_line("Q", CH_CR);
        send_line(" \tq\t ", CH_LF);
        send_line("Qx", CH_CR);
        send_line("", CH_CR);
        send_line("   ", CH_NUL);
        send_line("3 + 4 x", CH_CR);
        send_line("1\010+2", CH_CR);
        send_line("1+2\177", CH_LF);
        send_line("+5", CH_CR);
        send_line("5+", CH_CR);
        send_line("4*\t\t6\377", CH_CR);
        repeat (30) line_buf.push_back(CH_SPACE);
        send_line("1+2", CH_CR);
        repeat (28) line_buf.push_back(CH_SPACE);
        send_line("1+2", CH_LF);
        drain();

        // long receiver stall while requests keep coming
        hold_req = 300;
        send_line("123*45", CH_CR);
        send_line("60000/7", CH_CR);
        send_line("8-3", CH_LF);
        send_line("q", CH_CR);
        send_line("250*250", CH_NUL);
        send_line("9/3", CH_CR);
        drain();

        random_phase(9, 83, 500);
        random_phase(83, 9, 500);
        random_phase(0, 0, 500);
        drain();
        repeat (40) @(posedge aclk);

        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
